// ----- design/affine_xor_byte_cipher_macros.svh -----
// Assertion macros for the verification files of the byte cipher.
// Depends on nothing; included by the checker module.
`ifndef AFFINE_XOR_BYTE_CIPHER_MACROS_SVH
`define AFFINE_XOR_BYTE_CIPHER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AXBC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("axbc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AXBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("axbc assertion failed");

`endif

// ----- design/axbc_pkg.sv -----
// Shared types and constants of the affine XOR byte cipher.
// Depends on nothing; used by the inverse unit, the cipher top level and the checker.
package axbc_pkg;

    localparam int BYTE_W        = 8;
    localparam int MAX_KEY_BYTES = 32;
    localparam int POS_W         = $clog2(MAX_KEY_BYTES);
    localparam int LEN_W         = 6;
    localparam int KEY_WORD_W    = 64;
    localparam int KEY_WORDS     = (MAX_KEY_BYTES * BYTE_W) / KEY_WORD_W;
    localparam int APB_DATA_W    = 64;
    localparam int APB_ADDR_W    = 6;

    // Newton steps for the inverse mod 256; each step takes two multiplies.
    localparam int INV_STEPS     = 3;
    localparam int INV_CYCLES    = 2 * INV_STEPS;
    localparam int INV_CNT_W     = $clog2(INV_CYCLES);

    typedef logic [BYTE_W-1:0] byte_t;

    // Register indexes; register i sits at byte address 8*i.
    typedef enum logic [2:0] {
        REG_MODE, REG_MULT, REG_KEY_LEN, REG_KEY_W0, REG_KEY_W1, REG_KEY_W2, REG_KEY_W3
    } reg_idx_t;

    typedef struct packed {
        logic  busy;
        byte_t value;
    } inv_status_t;

endpackage

// ----- design/axbc_inverse.sv -----
// Iterative unit that finds the inverse of the multiplier modulo 256.
// Depends on axbc_pkg; instantiated by the cipher top level.
module axbc_inverse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  axbc_pkg::byte_t      seed,
    output axbc_pkg::inv_status_t status
);
    import axbc_pkg::*;

    byte_t                m_reg;
    byte_t                v_reg;
    byte_t                t_reg;
    logic                 busy_reg;
    logic [INV_CNT_W-1:0] cnt_reg;
    logic [2*BYTE_W-1:0]  product;
    byte_t                operand;

    // Even counts form t = 2 - m*v, odd counts form v = v*t.
    assign operand = cnt_reg[0] ? t_reg : m_reg;
    assign product = v_reg * operand;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg    <= byte_t'(1);
            v_reg    <= byte_t'(1);
            t_reg    <= '0;
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            m_reg    <= seed;
            v_reg    <= seed;
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg[0])
                v_reg <= product[BYTE_W-1:0];
            else
                t_reg <= byte_t'(2) - product[BYTE_W-1:0];
            if (cnt_reg == INV_CNT_W'(INV_CYCLES - 1))
                busy_reg <= 1'b0;
            cnt_reg <= cnt_reg + INV_CNT_W'(1);
        end
    end

    // An even multiplier has no inverse and reads as zero.
    assign status.busy  = busy_reg;
    assign status.value = m_reg[0] ? v_reg : '0;

endmodule

// ----- design/affine_xor_byte_cipher.sv -----
// Affine XOR byte cipher: one request per clock cycle unless output back-pressure or a
// busy inverse unit stalls the input. Each accepted byte is latched with its key byte
// in an input stage, and the next stage applies one 8x8 multiply, the additive term and
// the key XOR before the result register. After a write to the multiplier register the
// input stalls while the inverse unit's own 8x8 multiplier runs three Newton steps.
// Depends on axbc_pkg and axbc_inverse.
module affine_xor_byte_cipher (
    input  logic                           clk,
    input  logic                           rst_n,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [axbc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [axbc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [axbc_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    // Input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  axbc_pkg::byte_t                data_byte,
    input  logic                           message_end,
    // Output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output axbc_pkg::byte_t                result_byte,
    output logic                           result_last,
    output logic                           even_multiplier_error
);
    import axbc_pkg::*;

    // Configuration registers: user changes only with the pipeline empty; unchecked.
    logic                  mode_reg;
    byte_t                 mult_reg;
    logic [LEN_W-1:0]      key_len_reg;
    logic [KEY_WORD_W-1:0] key_word_reg [KEY_WORDS];

    logic                  cfg_write;
    reg_idx_t              reg_idx;
    inv_status_t           inv_status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = reg_idx_t'(paddr[APB_ADDR_W-1:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            mult_reg    <= byte_t'(1);
            key_len_reg <= LEN_W'(1);
            for (int w = 0; w < KEY_WORDS; w++)
                key_word_reg[w] <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_MODE:    mode_reg        <= pwdata[0];
                REG_MULT:    mult_reg        <= pwdata[BYTE_W-1:0];
                REG_KEY_LEN: key_len_reg     <= pwdata[LEN_W-1:0];
                REG_KEY_W0:  key_word_reg[0] <= pwdata;
                REG_KEY_W1:  key_word_reg[1] <= pwdata;
                REG_KEY_W2:  key_word_reg[2] <= pwdata;
                REG_KEY_W3:  key_word_reg[3] <= pwdata;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MODE:    prdata = {{(APB_DATA_W-1){1'b0}}, mode_reg};
            REG_MULT:    prdata = {{(APB_DATA_W-BYTE_W){1'b0}}, mult_reg};
            REG_KEY_LEN: prdata = {{(APB_DATA_W-LEN_W){1'b0}}, key_len_reg};
            REG_KEY_W0:  prdata = key_word_reg[0];
            REG_KEY_W1:  prdata = key_word_reg[1];
            REG_KEY_W2:  prdata = key_word_reg[2];
            REG_KEY_W3:  prdata = key_word_reg[3];
            default:     prdata = '0;
        endcase
    end

    // The inverse unit restarts on every multiplier write.
    axbc_inverse u_inverse (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cfg_write && (reg_idx == REG_MULT)),
        .seed   (pwdata[BYTE_W-1:0]),
        .status (inv_status)
    );

    // A key length of zero acts as one, and anything above the key store saturates.
    logic [LEN_W-1:0] eff_len;

    always_comb
    begin
        if (key_len_reg == '0)
            eff_len = LEN_W'(1);
        else if (key_len_reg > LEN_W'(MAX_KEY_BYTES))
            eff_len = LEN_W'(MAX_KEY_BYTES);
        else
            eff_len = key_len_reg;
    end

    // Key position: a position left stale by a shorter key length counts as zero.
    logic [POS_W-1:0] key_pos_reg;
    logic [POS_W-1:0] pos_cur;
    logic [POS_W:0]   pos_inc;
    logic [POS_W-1:0] key_pos_next;
    logic [MAX_KEY_BYTES*BYTE_W-1:0] key_flat;
    byte_t            key_sel;

    assign pos_cur = ({1'b0, key_pos_reg} >= eff_len) ? '0 : key_pos_reg;
    assign pos_inc = {1'b0, pos_cur} + (POS_W+1)'(1);
    assign key_pos_next = (pos_inc >= eff_len || message_end) ? '0 : pos_inc[POS_W-1:0];

    always_comb
    begin
        for (int w = 0; w < KEY_WORDS; w++)
            key_flat[w*KEY_WORD_W +: KEY_WORD_W] = key_word_reg[w];
    end

    assign key_sel = key_flat[{pos_cur, 3'b000} +: BYTE_W];

    // Two-stage pipeline with a ready per stage, so the input stage can still take a
    // request while a finished result waits at a stalled output.
    logic  s1_valid_reg;
    byte_t s1_data_reg;
    byte_t s1_key_reg;
    logic  s1_last_reg;
    logic  s2_valid_reg;
    byte_t s2_result_reg;
    logic  s2_last_reg;
    logic  s2_err_reg;
    logic  s2_ready;
    logic  s1_ready;
    logic  in_accept;

    assign s2_ready  = !s2_valid_reg || !out_stall;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_stall  = !s1_ready || inv_status.busy;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_pos_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                key_pos_reg <= key_pos_next;
            if (s1_ready)
                s1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_data_reg <= data_byte;
            s1_key_reg  <= key_sel;
            s1_last_reg <= message_end;
        end
    end

    // Encode: (m*x + L) ^ k.  Decode: inv*((y ^ k) - L).  One multiplier serves both.
    byte_t               len_byte;
    byte_t               mul_a;
    byte_t               mul_b;
    logic [2*BYTE_W-1:0] mul_p;
    byte_t               cipher_out;
    logic                err;

    assign len_byte   = {{(BYTE_W-LEN_W){1'b0}}, eff_len};
    assign mul_a      = mode_reg ? inv_status.value : mult_reg;
    assign mul_b      = mode_reg ? ((s1_data_reg ^ s1_key_reg) - len_byte) : s1_data_reg;
    assign mul_p      = mul_a * mul_b;
    assign cipher_out = mode_reg ? mul_p[BYTE_W-1:0]
                                 : ((mul_p[BYTE_W-1:0] + len_byte) ^ s1_key_reg);
    assign err        = !mult_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_ready)
            s2_valid_reg <= s1_valid_reg;
    end

    // An even multiplier passes the byte through untouched and flags it.
    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_result_reg <= err ? s1_data_reg : cipher_out;
            s2_last_reg   <= s1_last_reg;
            s2_err_reg    <= err;
        end
    end

    assign out_valid             = s2_valid_reg;
    assign result_byte           = s2_result_reg;
    assign result_last           = s2_last_reg;
    assign even_multiplier_error = s2_err_reg;

endmodule

// ----- design/axbc_checker.sv -----
// Port-level checker for the affine XOR byte cipher, bound to the top level.
// Depends on axbc_pkg and affine_xor_byte_cipher_macros.svh.
`include "affine_xor_byte_cipher_macros.svh"

module axbc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [axbc_pkg::APB_ADDR_W-1:0] paddr,
    input logic                            pready,
    input logic                            in_valid,
    input logic                            in_stall,
    input axbc_pkg::byte_t                 data_byte,
    input logic                            message_end,
    input logic                            out_valid,
    input logic                            out_stall,
    input axbc_pkg::byte_t                 result_byte,
    input logic                            result_last,
    input logic                            even_multiplier_error
);
    import axbc_pkg::*;

    logic              mult_write;
    logic [BYTE_W:0]   req_bundle;
    logic [BYTE_W+1:0] result_bundle;

    assign mult_write    = psel && penable && pwrite && pready
                           && (reg_idx_t'(paddr[APB_ADDR_W-1:3]) == REG_MULT);
    assign req_bundle    = {data_byte, message_end};
    assign result_bundle = {result_byte, result_last, even_multiplier_error};

    // A stalled request stays offered and unchanged.
    `AXBC_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable(req_bundle))

    // A held result stays offered and unchanged.
    `AXBC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `AXBC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(result_bundle))

    // Input stalls from the multiplier write until the inverse is ready.
    `AXBC_ASSERT_NEXT(a_inv_stall_start, clk, rst_n, mult_write, in_stall)
    `AXBC_ASSERT_IMP(a_inv_stall_end, clk, rst_n, mult_write, ##6 in_stall)

endmodule

bind affine_xor_byte_cipher axbc_checker u_axbc_checker (.*);

// ----- sim/affine_xor_byte_cipher_tb.sv -----
// Self-checking testbench for the affine XOR byte cipher: directed corner cases, then
// randomized message streams with random stalls on both channels and APB reconfiguration.
// Depends on axbc_pkg and the affine_xor_byte_cipher RTL.
module affine_xor_byte_cipher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import axbc_pkg::*;

    // This bound only catches a hung block.
    localparam int CYCLE_LIMIT   = 200000;
    // Idle margin kept after the last result is back.
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 80;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 95;

    // Register map order; register i sits at byte address 8*i because the key words
    // are 64 bits wide. The spare index has no register behind it.
    typedef enum int {
        REG_MODE,
        REG_MULTIPLIER,
        REG_KEY_LENGTH,
        REG_KEY_WORD_0,
        REG_KEY_WORD_1,
        REG_KEY_WORD_2,
        REG_KEY_WORD_3,
        REG_SPARE
    } cfg_reg_e;

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } cipher_mode_e;

    typedef struct packed {
        byte_t value;
        logic  last;
    } byte_req_t;

    typedef struct packed {
        byte_t value;
        logic  last;
        logic  err;
    } cipher_result_t;

    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    byte_t                 data_byte   = '0;
    logic                  message_end = 1'b0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    byte_t                 result_byte;
    logic                  result_last;
    logic                  even_multiplier_error;

    // Shadow copy of the block's configuration and running state.
    cipher_mode_e      cfg_mode    = MODE_ENCODE;
    byte_t             cfg_mult    = 8'd1;
    logic [LEN_W-1:0]  cfg_key_len = 6'd1;
    logic [255:0]      key_bits    = '0;
    byte_t             inv_mult    = 8'd1;
    logic [POS_W-1:0]  key_pos     = '0;

    byte_req_t         pending_bytes[$];
    cipher_result_t    expected_results[$];
    int unsigned       queued_cnt    = 0;
    int unsigned       accepted_cnt  = 0;
    int unsigned       mismatch_cnt  = 0;
    int unsigned       cycle_cnt     = 0;
    logic              in_fire       = 1'b0;

    // Idle rates in percent, and the long receiver hold-off handshake.
    int unsigned       send_idle_pct = 31;
    int unsigned       recv_idle_pct = 31;
    logic              hold_go       = 1'b0;
    int unsigned       hold_left     = 0;

    affine_xor_byte_cipher uut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .data_byte             (data_byte),
        .message_end           (message_end),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .result_byte           (result_byte),
        .result_last           (result_last),
        .even_multiplier_error (even_multiplier_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Inverse mod 256 found by trying every odd candidate; an even multiplier has none,
    // and the block then holds zero.
    function automatic byte_t find_inverse(byte_t m);
        byte_t cand;
        if (!m[0])
            return 8'd0;
        for (int i = 1; i < 256; i += 2)
        begin
            cand = byte_t'(i);
            if (byte_t'(m * cand) == 8'd1)
                return cand;
        end
        return 8'd0;
    endfunction

    // Works out the result of one request and advances the key position.
    function automatic cipher_result_t cipher_byte(byte_t din, logic last);
        int unsigned    period;
        int unsigned    pos;
        byte_t          key;
        byte_t          unmasked;
        cipher_result_t res;
        // A zero length acts as one and anything above the key store saturates.
        period = (cfg_key_len == 0) ? 1 :
                 (cfg_key_len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : cfg_key_len;
        // A position left beyond a shortened key restarts at the first key byte.
        pos = key_pos;
        if (pos >= period)
            pos = 0;
        key      = key_bits[8*pos +: 8];
        res.last = last;
        res.err  = ~cfg_mult[0];
        if (res.err)
            res.value = din;
        else if (cfg_mode == MODE_ENCODE)
            res.value = byte_t'(cfg_mult * din + byte_t'(period)) ^ key;
        else
        begin
            unmasked  = (din ^ key) - byte_t'(period);
            res.value = inv_mult * unmasked;
        end
        // The position advances in every mode, even-multiplier passthrough included.
        pos++;
        if (pos >= period || last)
            pos = 0;
        key_pos = POS_W'(pos);
        return res;
    endfunction

    // Request driver: a new byte is offered only once the previous one has been taken,
    // so a stalled payload never changes.
    always @(negedge clk)
    begin
        byte_req_t req;
        if (rst_n && (!in_valid || in_fire))
        begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req = pending_bytes.pop_front();
                in_valid    <= 1'b1;
                data_byte   <= req.value;
                message_end <= req.last;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request so that the
    // block fills up and pushes back on its input.
    always @(negedge clk)
    begin
        if (hold_go)
        begin
            hold_left = HOLD_CYCLES;
            hold_go   = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Monitor: predicts each accepted request and checks each accepted result against
    // the oldest prediction.
    always @(posedge clk)
    begin
        cipher_result_t want;
        cycle_cnt++;
        in_fire <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            expected_results.push_back(cipher_byte(data_byte, message_end));
            accepted_cnt++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: result_byte %02h with no request pending",
                       result_byte);
                mismatch_cnt++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result_byte !== want.value)
                begin
                    $error("result_byte: expected %02h, actual %02h", want.value, result_byte);
                    mismatch_cnt++;
                end
                if (result_last !== want.last)
                begin
                    $error("result_last: expected %0b, actual %0b", want.last, result_last);
                    mismatch_cnt++;
                end
                if (even_multiplier_error !== want.err)
                begin
                    $error("even_multiplier_error: expected %0b, actual %0b",
                           want.err, even_multiplier_error);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_byte(byte_t value, logic last);
        byte_req_t req;
        req.value = value;
        req.last  = last;
        pending_bytes.push_back(req);
        queued_cnt++;
    endtask

    // Blocks until every queued request has been accepted and answered.
    task automatic wait_idle();
        while (accepted_cnt != queued_cnt || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One APB write (setup then access), mirrored into the shadow configuration.
    // Only called while the block is idle.
    task automatic write_reg(cfg_reg_e idx, logic [APB_DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(8 * int'(idx));
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MODE:       cfg_mode = cipher_mode_e'(value[0]);
            REG_MULTIPLIER:
            begin
                cfg_mult = value[7:0];
                inv_mult = find_inverse(cfg_mult);
            end
            REG_KEY_LENGTH: cfg_key_len = value[LEN_W-1:0];
            REG_KEY_WORD_0, REG_KEY_WORD_1, REG_KEY_WORD_2, REG_KEY_WORD_3:
                key_bits[64*(int'(idx) - int'(REG_KEY_WORD_0)) +: 64] = value;
            default: ;
        endcase
    endtask

    task automatic write_random_keys();
        for (int w = 0; w < 4; w++)
            write_reg(cfg_reg_e'(int'(REG_KEY_WORD_0) + w), {$urandom(), $urandom()});
    endtask

    // Random setting for one phase: mostly odd multipliers, key lengths weighted toward
    // the extremes and the out-of-range values.
    task automatic write_random_config();
        int unsigned pick;
        logic [APB_DATA_W-1:0] len;
        byte_t mult;
        write_reg(REG_MODE, APB_DATA_W'($urandom_range(1)));
        mult = byte_t'($urandom_range(255));
        if ($urandom_range(99) < 85)
            mult[0] = 1'b1;
        write_reg(REG_MULTIPLIER, APB_DATA_W'(mult));
        pick = $urandom_range(9);
        case (pick)
            0:       len = 0;
            1:       len = APB_DATA_W'($urandom_range(63, MAX_KEY_BYTES + 1));
            2:       len = MAX_KEY_BYTES;
            3:       len = 1;
            default: len = APB_DATA_W'($urandom_range(MAX_KEY_BYTES - 1, 2));
        endcase
        write_reg(REG_KEY_LENGTH, len);
        write_random_keys();
    endtask

    // Mostly whole messages of random length that end with a marked byte; the rest is
    // loose bytes with a random end mark. The last message is cut to fit the count.
    task automatic push_random_traffic(int unsigned n_items);
        int unsigned count;
        int unsigned msg_len;
        count = 0;
        while (count < n_items)
        begin
            if ($urandom_range(99) < 85)
            begin
                msg_len = $urandom_range(40, 1);
                if (msg_len > n_items - count)
                    msg_len = n_items - count;
                for (int i = 0; i < msg_len; i++)
                    push_byte(byte_t'($urandom_range(255)), (i == msg_len - 1));
                count += msg_len;
            end
            else
            begin
                push_byte(byte_t'($urandom_range(255)), 1'($urandom_range(1)));
                count++;
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset configuration: identity multiplier, one key byte of zero.
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h5A, 1'b0);
        wait_idle();

        // Wide writes keep only the register's bits: mode is left as encode, the
        // multiplier as 0xFF, and the key length as zero, which acts as one.
        write_reg(REG_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
        write_reg(REG_MULTIPLIER, 64'h0000_0001_0000_01FF);
        write_reg(REG_KEY_LENGTH, 64'h40);
        write_random_keys();
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        wait_idle();

        // Key length above the key store saturates to the full store.
        write_reg(REG_KEY_LENGTH, 63);
        write_reg(REG_MULTIPLIER, 64'h103);
        push_byte(8'h80, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'hFE, 1'b1);
        wait_idle();

        // Leave the key position at five, then shorten the key below it.
        write_reg(REG_KEY_LENGTH, 8);
        for (int i = 0; i < 5; i++)
            push_byte(byte_t'($urandom_range(255)), 1'b0);
        wait_idle();
        write_reg(REG_KEY_LENGTH, 3);
        push_byte(8'hC3, 1'b0);
        push_byte(8'h3C, 1'b1);
        wait_idle();

        // Even multipliers pass bytes through with the error flag set.
        write_reg(REG_MODE, MODE_DECODE);
        write_reg(REG_MULTIPLIER, 254);
        push_byte(8'hAA, 1'b0);
        push_byte(8'h55, 1'b1);
        wait_idle();
        write_reg(REG_MULTIPLIER, 0);
        push_byte(8'h3C, 1'b1);
        wait_idle();

        // Decode with the largest multiplier and the full key.
        write_reg(REG_MULTIPLIER, 255);
        write_reg(REG_KEY_LENGTH, MAX_KEY_BYTES);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h96, 1'b1);
        wait_idle();

        // A write to an unmapped index must leave the configuration alone.
        write_reg(REG_SPARE, {$urandom(), $urandom()});
        push_byte(8'h69, 1'b1);
        wait_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_random_config();
            case (phase)
                1:
                begin
                    // Long receiver hold-off while the sender keeps offering requests.
                    push_random_traffic(PHASE_ITEMS);
                    hold_go = 1'b1;
                end
                3:
                begin
                    // Back-to-back traffic with no idling on either side.
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    push_random_traffic(PHASE_ITEMS);
                    wait_idle();
                    send_idle_pct = 31;
                    recv_idle_pct = 31;
                end
                5:
                begin
                    // The sender pauses mid-phase until every result is back.
                    push_random_traffic(PHASE_ITEMS / 2);
                    wait_idle();
                    push_random_traffic(PHASE_ITEMS - PHASE_ITEMS / 2);
                end
                default: push_random_traffic(PHASE_ITEMS);
            endcase
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
